// ----- sv/mpe_pkg.sv -----
`default_nettype none
package mpe_pkg;

    localparam int MAX_REPEAT = 32;
    localparam int CNT_W      = $clog2(MAX_REPEAT + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PACKET_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_START   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_MAX     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_FACTOR  = 2'd3;

    // Packet format codes; code 3 is unused and emits nothing
    typedef enum logic [1:0] {
        FMT_MOUSESYSTEMS = 2'd0,
        FMT_IMPS2        = 2'd1,
        FMT_ISERIAL      = 2'd2
    } fmt_t;

    // Button bits in the held mask
    localparam int HELD_LEFT   = 2;
    localparam int HELD_MIDDLE = 1;
    localparam int HELD_RIGHT  = 0;

    localparam logic [2:0] LEN_MOUSESYSTEMS = 3'd5;
    localparam logic [2:0] LEN_FOUR_BYTE    = 3'd4;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } mpe_state_t;

    typedef struct packed {
        logic load;
        logic advance;
    } mpe_cmd_t;

    typedef struct packed {
        logic burst_empty;
        logic last;
    } mpe_status_t;

endpackage
`default_nettype wire

// ----- sv/mpe_event_if.sv -----
`default_nettype none
interface mpe_event_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
    logic signed [7:0] delta_wheel;
    logic        [7:0] repeat_count;
    logic        [2:0] press_mask;
    logic        [2:0] release_mask;

    modport source (
        output valid, delta_x, delta_y, delta_wheel, repeat_count, press_mask,
               release_mask,
        input  ready
    );
    modport sink (
        input  valid, delta_x, delta_y, delta_wheel, repeat_count, press_mask,
               release_mask,
        output ready
    );
endinterface
`default_nettype wire

// ----- sv/mpe_packet_if.sv -----
`default_nettype none
interface mpe_packet_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte0;
    logic [7:0] packet_byte1;
    logic [7:0] packet_byte2;
    logic [7:0] packet_byte3;
    logic [7:0] packet_byte4;
    logic [2:0] packet_length;
    logic       last_in_burst;

    modport source (
        output valid, packet_byte0, packet_byte1, packet_byte2, packet_byte3,
               packet_byte4, packet_length, last_in_burst,
        input  ready
    );
    modport sink (
        input  valid, packet_byte0, packet_byte1, packet_byte2, packet_byte3,
               packet_byte4, packet_length, last_in_burst,
        output ready
    );
endinterface
`default_nettype wire

// ----- sv/mpe_cfg_if.sv -----
`default_nettype none
interface mpe_cfg_if
    import mpe_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- sv/mpe_ctrl.sv -----
`default_nettype none
module mpe_ctrl
    import mpe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        out_ready,
    input  wire mpe_status_t status,
    output logic             in_ready,
    output logic             out_valid,
    output mpe_cmd_t         cmd
);

    mpe_state_t state_reg;
    mpe_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.load    = 1'b0;
        cmd.advance = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    // empty bursts only update the held buttons
                    if (!status.burst_empty)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.advance = 1'b1;
                    if (status.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/mpe_datapath.sv -----
`default_nettype none
module mpe_datapath
    import mpe_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mpe_cmd_t              cmd,
    output mpe_status_t                status,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic signed [7:0]     delta_x,
    input  wire logic signed [7:0]     delta_y,
    input  wire logic signed [7:0]     delta_wheel,
    input  wire logic        [7:0]     repeat_count,
    input  wire logic        [2:0]     press_mask,
    input  wire logic        [2:0]     release_mask,
    output logic             [7:0]     packet_byte0,
    output logic             [7:0]     packet_byte1,
    output logic             [7:0]     packet_byte2,
    output logic             [7:0]     packet_byte3,
    output logic             [7:0]     packet_byte4,
    output logic             [2:0]     packet_length,
    output logic                       last_in_burst
);

    logic [1:0]       format_reg;
    logic [7:0]       accel_start_reg;
    logic [5:0]       accel_max_reg;
    logic [5:0]       accel_factor_reg;
    logic [2:0]       held_reg;
    logic [2:0]       held_next;
    logic [CNT_W-1:0] remain_reg;

    logic [7:0] byte0_reg, byte1_reg, byte2_reg, byte3_reg;
    logic [2:0] len_reg;
    logic [7:0] byte0_next, byte1_next, byte2_next, byte3_next;
    logic [2:0] len_next;
    logic       fmt_valid;

    logic [13:0]      prod;
    logic [5:0]       accel_count;
    logic [CNT_W-1:0] burst_next;
    logic [7:0]       neg_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg       <= FMT_MOUSESYSTEMS;
            accel_start_reg  <= 8'd2;
            accel_max_reg    <= 6'd20;
            accel_factor_reg <= 6'd2;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PACKET_FORMAT: format_reg       <= cfg_data[1:0];
                REG_ACCEL_START:   accel_start_reg  <= cfg_data;
                REG_ACCEL_MAX:     accel_max_reg    <= cfg_data[5:0];
                REG_ACCEL_FACTOR:  accel_factor_reg <= cfg_data[5:0];
                default:           ;
            endcase
        end
    end

    // Burst length: one packet below the acceleration start, else the scaled
    // repeat count limited by the configured maximum and the burst depth
    always_comb
    begin
        prod        = repeat_count * {2'b00, accel_factor_reg};
        accel_count = (prod >= {8'd0, accel_max_reg}) ? accel_max_reg : prod[5:0];
        if (repeat_count < accel_start_reg)
        begin
            burst_next = CNT_W'(1);
        end
        else if ({1'b0, accel_count} > 7'(MAX_REPEAT))
        begin
            burst_next = CNT_W'(MAX_REPEAT);
        end
        else
        begin
            burst_next = CNT_W'(accel_count);
        end
    end

    assign held_next = (held_reg | press_mask) & ~release_mask;
    assign neg_y     = 8'd0 - delta_y;

    always_comb
    begin
        byte0_next = 8'h00;
        byte1_next = delta_x;
        byte2_next = delta_y;
        byte3_next = 8'h00;
        len_next   = LEN_FOUR_BYTE;
        fmt_valid  = 1'b1;
        unique case (format_reg)
            FMT_MOUSESYSTEMS:
            begin
                byte0_next = {5'b10000, ~held_next};
                len_next   = LEN_MOUSESYSTEMS;
            end
            FMT_IMPS2:
            begin
                byte0_next = {2'b00, delta_y[7], delta_x[7], 1'b1,
                              held_next[HELD_MIDDLE], held_next[HELD_RIGHT],
                              held_next[HELD_LEFT]};
                byte3_next = delta_wheel;
            end
            FMT_ISERIAL:
            begin
                byte0_next = {2'b01, held_next[HELD_LEFT], held_next[HELD_RIGHT],
                              neg_y[7:6], delta_x[7:6]};
                byte1_next = {2'b00, delta_x[5:0]};
                byte2_next = {2'b00, neg_y[5:0]};
                byte3_next = {3'b000, held_next[HELD_MIDDLE],
                              {3{delta_wheel[7]}}, (delta_wheel != 8'sd0)};
            end
            default:
            begin
                fmt_valid = 1'b0;
            end
        endcase
    end

    assign status.burst_empty = !fmt_valid || (burst_next == '0);
    assign status.last        = (remain_reg == CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= 3'b000;
            remain_reg <= '0;
        end
        else if (cmd.load)
        begin
            held_reg   <= held_next;
            remain_reg <= burst_next;
        end
        else if (cmd.advance)
        begin
            remain_reg <= remain_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte0_reg <= byte0_next;
            byte1_reg <= byte1_next;
            byte2_reg <= byte2_next;
            byte3_reg <= byte3_next;
            len_reg   <= len_next;
        end
    end

    assign packet_byte0  = byte0_reg;
    assign packet_byte1  = byte1_reg;
    assign packet_byte2  = byte2_reg;
    assign packet_byte3  = byte3_reg;
    assign packet_byte4  = 8'h00;
    assign packet_length = len_reg;
    assign last_in_burst = status.last;

endmodule
`default_nettype wire

// ----- sv/mouse_packet_encoder.sv -----
`default_nettype none
// Mouse packet encoder. Each event word updates the 3-bit held-button state
// (presses set first, releases then clear, so a release wins) and builds one
// packet in the configured format: MouseSystems (5 bytes), IMPS/2 (4 bytes)
// or IntelliMouse serial (4 bytes, y negated). The packet is repeated f
// times on the packet channel, the last word flagged by last_in_burst. f is 1
// below accel_start, otherwise repeat_count * accel_factor limited to
// accel_max and to 32; f may be 0, and format code 3 emits nothing, but the
// held buttons still update. An event is accepted in the idle state, then
// the burst down-counter releases one packet per cycle while the sink keeps
// ready high. Events are taken only while no burst is pending. Configuration
// writes are always ready and belong to idle periods.
module mouse_packet_encoder
    import mpe_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    mpe_event_if.sink    events,
    mpe_packet_if.source packets,
    mpe_cfg_if.sink      cfg
);

    mpe_cmd_t    cmd;
    mpe_status_t status;
    logic        cfg_write;

    // Registers take a write in any cycle
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid;

    // Sequence the burst: accept, then release packets until the last
    mpe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (events.valid),
        .out_ready (packets.ready),
        .status    (status),
        .in_ready  (events.ready),
        .out_valid (packets.valid),
        .cmd       (cmd)
    );

    // Hold configuration, button state, the packet register and burst count
    mpe_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .delta_x       (events.delta_x),
        .delta_y       (events.delta_y),
        .delta_wheel   (events.delta_wheel),
        .repeat_count  (events.repeat_count),
        .press_mask    (events.press_mask),
        .release_mask  (events.release_mask),
        .packet_byte0  (packets.packet_byte0),
        .packet_byte1  (packets.packet_byte1),
        .packet_byte2  (packets.packet_byte2),
        .packet_byte3  (packets.packet_byte3),
        .packet_byte4  (packets.packet_byte4),
        .packet_length (packets.packet_length),
        .last_in_burst (packets.last_in_burst)
    );

endmodule
`default_nettype wire
